// ----- rtl/core/ibk_pkg.sv -----
// Shared types and codes for the interval bitwise known-bits pipeline.
`timescale 1ns / 1ps

package ibk_pkg;

	// Width of every bound field on the ports
	localparam int FIELD_W = 32;

	// Operation codes; the fourth code has no operation
	typedef enum logic [1:0] {
		ACT_AND = 2'd0,
		ACT_OR  = 2'd1,
		ACT_XOR = 2'd2
	} act_t;

	// Control that travels down the pipeline with each item
	typedef struct packed {
		logic vld;
		act_t act;
		logic sgn;
	} ibk_ctl_t;

endpackage

// ----- rtl/core/ibk_mask_stage.sv -----
// Stage 2: known-bit masks of both intervals and the single-value shortcut.
`timescale 1ns / 1ps

module ibk_mask_stage #(
	parameter int WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  ibk_pkg::ibk_ctl_t    ctl_s1,
	input  logic [WIDTH-1:0]     lo_a_s1,
	input  logic [WIDTH-1:0]     hi_a_s1,
	input  logic [WIDTH-1:0]     lo_b_s1,
	input  logic [WIDTH-1:0]     hi_b_s1,
	output ibk_pkg::ibk_ctl_t    ctl_s2,
	output logic [WIDTH-1:0]     lo_a_s2,
	output logic [WIDTH-1:0]     hi_a_s2,
	output logic [WIDTH-1:0]     lo_b_s2,
	output logic [WIDTH-1:0]     hi_b_s2,
	output logic [WIDTH-1:0]     may_a_s2,
	output logic [WIDTH-1:0]     must_a_s2,
	output logic [WIDTH-1:0]     may_b_s2,
	output logic [WIDTH-1:0]     must_b_s2,
	output logic                 sc_hit_s2,
	output logic [WIDTH-1:0]     sc_lo_s2,
	output logic [WIDTH-1:0]     sc_hi_s2
);
	import ibk_pkg::*;

	localparam int SMEAR_STEPS = $clog2(WIDTH);

	// Ones at and below the highest set bit
	function automatic logic [WIDTH-1:0] smear(input logic [WIDTH-1:0] v);
		logic [WIDTH-1:0] r;
		r = v;
		for (int i = 0; i < SMEAR_STEPS; i++) begin
			r = r | (r >> (1 << i));
		end
		return r;
	endfunction

	// {may, must} for one interval
	function automatic logic [2*WIDTH-1:0] known(input logic s,
		input logic [WIDTH-1:0] lo, input logic [WIDTH-1:0] hi);
		logic [WIDTH-1:0] may;
		logic [WIDTH-1:0] must;
		logic [WIDTH-1:0] m;
		may  = '1;
		must = '0;
		m    = smear(lo ^ hi) >> 1;
		if (lo == hi) begin
			may  = lo;
			must = lo;
		end else if (!(s && lo[WIDTH-1]) || (s && hi[WIDTH-1])) begin
			may  = lo | hi | m;
			must = lo & hi & ~m;
		end
		return {may, must};
	endfunction

	logic [2*WIDTH-1:0] kb_a;
	logic [2*WIDTH-1:0] kb_b;
	logic               sel_b;
	logic               is_or;
	logic [WIDTH-1:0]   k;
	logic [WIDTH-1:0]   v_lo;
	logic [WIDTH-1:0]   v_hi;
	logic [WIDTH-1:0]   w;
	logic [WIDTH-1:0]   fill;
	logic [WIDTH-1:0]   low_mask;
	logic               sc_hit;
	logic [WIDTH-1:0]   sc_lo;
	logic [WIDTH-1:0]   sc_hi;

	assign kb_a = known(ctl_s1.sgn, lo_a_s1, hi_a_s1);
	assign kb_b = known(ctl_s1.sgn, lo_b_s1, hi_b_s1);

	// Shortcut: the constant operand's lowest run of effective ones must span
	// every bit where the other interval's bounds differ
	always_comb begin
		sel_b    = (lo_b_s1 == hi_b_s1);
		is_or    = (ctl_s1.act == ACT_OR);
		k        = sel_b ? lo_b_s1 : lo_a_s1;
		v_lo     = sel_b ? lo_a_s1 : lo_b_s1;
		v_hi     = sel_b ? hi_a_s1 : hi_b_s1;
		w        = is_or ? ~k : k;
		fill     = w | (w - WIDTH'(1));
		low_mask = fill & ~(fill + WIDTH'(1));
		sc_hit   = (sel_b || (lo_a_s1 == hi_a_s1)) && (((v_lo ^ v_hi) & ~low_mask) == '0);
		sc_lo    = is_or ? (v_lo | k) : (v_lo & k);
		sc_hi    = is_or ? (v_hi | k) : (v_hi & k);
	end

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			lo_a_s2   <= lo_a_s1;
			hi_a_s2   <= hi_a_s1;
			lo_b_s2   <= lo_b_s1;
			hi_b_s2   <= hi_b_s1;
			may_a_s2  <= kb_a[2*WIDTH-1:WIDTH];
			must_a_s2 <= kb_a[WIDTH-1:0];
			may_b_s2  <= kb_b[2*WIDTH-1:WIDTH];
			must_b_s2 <= kb_b[WIDTH-1:0];
			sc_hit_s2 <= sc_hit;
			sc_lo_s2  <= sc_lo;
			sc_hi_s2  <= sc_hi;
		end
	end

endmodule

// ----- rtl/core/ibk_bound_stage.sv -----
// Stage 3: first result from the masks, then sign-based tightening of one bound.
`timescale 1ns / 1ps

module ibk_bound_stage #(
	parameter int WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  ibk_pkg::ibk_ctl_t    ctl_s2,
	input  logic [WIDTH-1:0]     lo_a_s2,
	input  logic [WIDTH-1:0]     hi_a_s2,
	input  logic [WIDTH-1:0]     lo_b_s2,
	input  logic [WIDTH-1:0]     hi_b_s2,
	input  logic [WIDTH-1:0]     may_a_s2,
	input  logic [WIDTH-1:0]     must_a_s2,
	input  logic [WIDTH-1:0]     may_b_s2,
	input  logic [WIDTH-1:0]     must_b_s2,
	input  logic                 sc_hit_s2,
	input  logic [WIDTH-1:0]     sc_lo_s2,
	input  logic [WIDTH-1:0]     sc_hi_s2,
	output ibk_pkg::ibk_ctl_t    ctl_s3,
	output logic [WIDTH-1:0]     wmin_s3,
	output logic [WIDTH-1:0]     wmax_s3,
	output logic                 fix_s3,
	output logic                 sgn_case_s3
);
	import ibk_pkg::*;

	localparam logic [WIDTH-1:0] MSB_MASK = {1'b1, {(WIDTH-1){1'b0}}};

	function automatic logic lt(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b,
		input logic s);
		return s ? ((a ^ MSB_MASK) < (b ^ MSB_MASK)) : (a < b);
	endfunction

	logic             s;
	logic             is_or;
	logic             neg_la;
	logic             neg_ha;
	logic             neg_lb;
	logic             neg_hb;
	logic [WIDTH-1:0] base;
	logic [WIDTH-1:0] cand_a;
	logic [WIDTH-1:0] cand_b;
	logic             en_a;
	logic             en_b;
	logic             a_beats_base;
	logic             b_beats_base;
	logic             b_beats_a;
	logic [WIDTH-1:0] picked;
	logic [WIDTH-1:0] xor_zeros;
	logic [WIDTH-1:0] xor_ones;
	logic [WIDTH-1:0] wmin;
	logic [WIDTH-1:0] wmax;
	logic             fix;
	logic             sgn_case;

	// Tightening: max of lower bounds for OR, min of upper bounds for AND
	always_comb begin
		s      = ctl_s2.sgn;
		is_or  = (ctl_s2.act == ACT_OR);
		neg_la = s && lo_a_s2[WIDTH-1];
		neg_ha = s && hi_a_s2[WIDTH-1];
		neg_lb = s && lo_b_s2[WIDTH-1];
		neg_hb = s && hi_b_s2[WIDTH-1];
		if (is_or) begin
			base   = must_a_s2 | must_b_s2;
			cand_a = lo_a_s2;
			cand_b = lo_b_s2;
			en_a   = (!neg_la && !neg_lb) || neg_ha;
			en_b   = (!neg_la && !neg_lb) || neg_hb;
			a_beats_base = lt(base, cand_a, s);
			b_beats_base = lt(base, cand_b, s);
			b_beats_a    = lt(cand_a, cand_b, s);
		end else begin
			base   = may_a_s2 & may_b_s2;
			cand_a = hi_a_s2;
			cand_b = hi_b_s2;
			en_a   = (neg_ha && neg_hb) || !neg_la;
			en_b   = (neg_ha && neg_hb) || !neg_lb;
			a_beats_base = lt(cand_a, base, s);
			b_beats_base = lt(cand_b, base, s);
			b_beats_a    = lt(cand_b, cand_a, s);
		end
		picked = base;
		if (en_a && en_b) begin
			if (a_beats_base || b_beats_base) begin
				picked = b_beats_a ? cand_b : cand_a;
			end
		end else if (en_a) begin
			if (a_beats_base) begin
				picked = cand_a;
			end
		end else if (en_b) begin
			if (b_beats_base) begin
				picked = cand_b;
			end
		end
	end

	// Result bounds per operation
	always_comb begin
		xor_zeros = (must_a_s2 & must_b_s2) | ~(may_a_s2 | may_b_s2);
		xor_ones  = (must_a_s2 & ~may_b_s2) | (must_b_s2 & ~may_a_s2);
		wmin      = '0;
		wmax      = '0;
		fix       = 1'b0;
		unique case (ctl_s2.act)
			ACT_XOR: begin
				wmin = xor_ones;
				wmax = ~xor_zeros;
			end
			ACT_OR: begin
				if (sc_hit_s2) begin
					wmin = sc_lo_s2;
					wmax = sc_hi_s2;
					fix  = 1'b1;
				end else begin
					wmin = picked;
					wmax = may_a_s2 | may_b_s2;
				end
			end
			ACT_AND: begin
				if (sc_hit_s2) begin
					wmin = sc_lo_s2;
					wmax = sc_hi_s2;
					fix  = 1'b1;
				end else begin
					wmin = must_a_s2 & must_b_s2;
					wmax = picked;
				end
			end
			default: begin
				wmin = '0;
				wmax = '0;
			end
		endcase
		// Signed AND with the lone sign bit as one operand
		sgn_case = s && (((lo_a_s2 == hi_a_s2) && (lo_a_s2 == MSB_MASK)) ||
			((lo_b_s2 == hi_b_s2) && (lo_b_s2 == MSB_MASK)));
	end

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			wmin_s3     <= wmin;
			wmax_s3     <= wmax;
			fix_s3      <= fix;
			sgn_case_s3 <= sgn_case;
		end
	end

endmodule

// ----- rtl/core/ibk_final_stage.sv -----
// Stage 4: crossed-bound check, full-range fallback and the output register.
`timescale 1ns / 1ps

module ibk_final_stage #(
	parameter int WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  ibk_pkg::ibk_ctl_t             ctl_s3,
	input  logic [WIDTH-1:0]              wmin_s3,
	input  logic [WIDTH-1:0]              wmax_s3,
	input  logic                          fix_s3,
	input  logic                          sgn_case_s3,
	output ibk_pkg::ibk_ctl_t             ctl_s4,
	output logic [ibk_pkg::FIELD_W-1:0]   res_lo_s4,
	output logic [ibk_pkg::FIELD_W-1:0]   res_hi_s4,
	output logic                          ok_s4
);
	import ibk_pkg::*;

	localparam logic [WIDTH-1:0] MSB_MASK = {1'b1, {(WIDTH-1){1'b0}}};

	function automatic logic lt(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b,
		input logic s);
		return s ? ((a ^ MSB_MASK) < (b ^ MSB_MASK)) : (a < b);
	endfunction

	logic             s;
	logic             crossed;
	logic             good;
	logic [WIDTH-1:0] lo;
	logic [WIDTH-1:0] hi;
	logic [WIDTH-1:0] lo_s4;
	logic [WIDTH-1:0] hi_s4;

	// Validity of the computed interval, else full type range
	always_comb begin
		s       = ctl_s3.sgn;
		crossed = lt(wmax_s3, wmin_s3, s);
		lo      = wmin_s3;
		hi      = wmax_s3;
		good    = 1'b0;
		unique case (ctl_s3.act)
			ACT_XOR: begin
				good = (s && wmin_s3[WIDTH-1]) || !(s && wmax_s3[WIDTH-1]);
			end
			ACT_OR: begin
				good = fix_s3 || !crossed;
			end
			ACT_AND: begin
				if (fix_s3) begin
					good = 1'b1;
				end else if (crossed && sgn_case_s3) begin
					lo   = MSB_MASK;
					hi   = '0;
					good = 1'b1;
				end else begin
					good = !crossed;
				end
			end
			default: begin
				good = 1'b0;
			end
		endcase
		if (!good) begin
			lo = s ? MSB_MASK : '0;
			hi = s ? ~MSB_MASK : '1;
		end
	end

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_s3;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s4 <= lo;
			hi_s4 <= hi;
			ok_s4 <= good;
		end
	end

	// Fit the bounds to the port width
	generate
		if (WIDTH >= FIELD_W) begin : g_trunc
			assign res_lo_s4 = lo_s4[FIELD_W-1:0];
			assign res_hi_s4 = hi_s4[FIELD_W-1:0];
		end else begin : g_ext
			assign res_lo_s4 = {{(FIELD_W-WIDTH){1'b0}}, lo_s4};
			assign res_hi_s4 = {{(FIELD_W-WIDTH){1'b0}}, hi_s4};
		end
	endgenerate

	// Fallback gives the full unsigned range
	a_full_unsigned: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s4.vld && !ok_s4 && !ctl_s4.sgn |-> lo_s4 == '0 && hi_s4 == '1)
		else $error("unsigned fallback is not the full range");

	// Fallback gives the full signed range
	a_full_signed: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s4.vld && !ok_s4 && ctl_s4.sgn |-> lo_s4 == MSB_MASK && hi_s4 == ~MSB_MASK)
		else $error("signed fallback is not the full range");

	// The unused operation code never reports a computed interval
	a_no_op: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s4.vld && ctl_s4.act != ACT_AND && ctl_s4.act != ACT_OR &&
		ctl_s4.act != ACT_XOR |-> !ok_s4)
		else $error("unused operation reported ok");

	// A shortcut hit for AND or OR always ends valid
	a_shortcut_ok: assert property (@(posedge clk) disable iff (!arst_n)
		$past(en && ctl_s3.vld && fix_s3 &&
		(ctl_s3.act == ACT_AND || ctl_s3.act == ACT_OR)) |-> ok_s4)
		else $error("shortcut result lost its ok flag");

endmodule

// ----- rtl/core/interval_bitwise_known_bits_top.sv -----
// Top level of the interval AND/OR/XOR known-bits pipeline.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | sink      | in_valid / in_ready   | action, is_signed, lo_a, hi_a, lo_b, hi_b
//  out     | source    | out_valid / out_ready | res_lo, res_hi, ok
//
//  Four register stages (input, masks, bounds, output): each item passes them in order
//  and its result is offered from the output register; one item per cycle sustained
//  while out_ready is high.
//  All stages advance together whenever the output register is empty or being drained.
//  Reset clears the stage control (valid bit, action, sign) only; data registers are not reset.
//  While out_valid is high and out_ready low, every stage holds and in_ready is low.
`timescale 1ns / 1ps

module interval_bitwise_known_bits_top #(
	parameter int WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic                         is_signed,
	input  logic [ibk_pkg::FIELD_W-1:0]  lo_a,
	input  logic [ibk_pkg::FIELD_W-1:0]  hi_a,
	input  logic [ibk_pkg::FIELD_W-1:0]  lo_b,
	input  logic [ibk_pkg::FIELD_W-1:0]  hi_b,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ibk_pkg::FIELD_W-1:0]  res_lo,
	output logic [ibk_pkg::FIELD_W-1:0]  res_hi,
	output logic                         ok
);
	import ibk_pkg::*;

	logic             en;
	ibk_ctl_t         ctl_in;
	ibk_ctl_t         ctl_s1;
	ibk_ctl_t         ctl_s2;
	ibk_ctl_t         ctl_s3;
	ibk_ctl_t         ctl_s4;
	logic [WIDTH-1:0] lo_a_w;
	logic [WIDTH-1:0] hi_a_w;
	logic [WIDTH-1:0] lo_b_w;
	logic [WIDTH-1:0] hi_b_w;
	logic [WIDTH-1:0] lo_a_s1;
	logic [WIDTH-1:0] hi_a_s1;
	logic [WIDTH-1:0] lo_b_s1;
	logic [WIDTH-1:0] hi_b_s1;
	logic [WIDTH-1:0] lo_a_s2;
	logic [WIDTH-1:0] hi_a_s2;
	logic [WIDTH-1:0] lo_b_s2;
	logic [WIDTH-1:0] hi_b_s2;
	logic [WIDTH-1:0] may_a_s2;
	logic [WIDTH-1:0] must_a_s2;
	logic [WIDTH-1:0] may_b_s2;
	logic [WIDTH-1:0] must_b_s2;
	logic             sc_hit_s2;
	logic [WIDTH-1:0] sc_lo_s2;
	logic [WIDTH-1:0] sc_hi_s2;
	logic [WIDTH-1:0] wmin_s3;
	logic [WIDTH-1:0] wmax_s3;
	logic             fix_s3;
	logic             sgn_case_s3;

	// Global advance: output slot free or its transfer happening now
	assign en        = !ctl_s4.vld || out_ready;
	assign in_ready  = en;
	assign out_valid = ctl_s4.vld;

	assign ctl_in.vld = in_valid;
	assign ctl_in.act = act_t'(action);
	assign ctl_in.sgn = is_signed;

	// Fit port bounds to the working width
	generate
		if (WIDTH <= FIELD_W) begin : g_trunc
			assign lo_a_w = lo_a[WIDTH-1:0];
			assign hi_a_w = hi_a[WIDTH-1:0];
			assign lo_b_w = lo_b[WIDTH-1:0];
			assign hi_b_w = hi_b[WIDTH-1:0];
		end else begin : g_ext
			assign lo_a_w = {{(WIDTH-FIELD_W){1'b0}}, lo_a};
			assign hi_a_w = {{(WIDTH-FIELD_W){1'b0}}, hi_a};
			assign lo_b_w = {{(WIDTH-FIELD_W){1'b0}}, lo_b};
			assign hi_b_w = {{(WIDTH-FIELD_W){1'b0}}, hi_b};
		end
	endgenerate

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			lo_a_s1 <= lo_a_w;
			hi_a_s1 <= hi_a_w;
			lo_b_s1 <= lo_b_w;
			hi_b_s1 <= hi_b_w;
		end
	end

	ibk_mask_stage #(
		.WIDTH (WIDTH)
	) u_mask (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_s1    (ctl_s1),
		.lo_a_s1   (lo_a_s1),
		.hi_a_s1   (hi_a_s1),
		.lo_b_s1   (lo_b_s1),
		.hi_b_s1   (hi_b_s1),
		.ctl_s2    (ctl_s2),
		.lo_a_s2   (lo_a_s2),
		.hi_a_s2   (hi_a_s2),
		.lo_b_s2   (lo_b_s2),
		.hi_b_s2   (hi_b_s2),
		.may_a_s2  (may_a_s2),
		.must_a_s2 (must_a_s2),
		.may_b_s2  (may_b_s2),
		.must_b_s2 (must_b_s2),
		.sc_hit_s2 (sc_hit_s2),
		.sc_lo_s2  (sc_lo_s2),
		.sc_hi_s2  (sc_hi_s2)
	);

	ibk_bound_stage #(
		.WIDTH (WIDTH)
	) u_bound (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ctl_s2      (ctl_s2),
		.lo_a_s2     (lo_a_s2),
		.hi_a_s2     (hi_a_s2),
		.lo_b_s2     (lo_b_s2),
		.hi_b_s2     (hi_b_s2),
		.may_a_s2    (may_a_s2),
		.must_a_s2   (must_a_s2),
		.may_b_s2    (may_b_s2),
		.must_b_s2   (must_b_s2),
		.sc_hit_s2   (sc_hit_s2),
		.sc_lo_s2    (sc_lo_s2),
		.sc_hi_s2    (sc_hi_s2),
		.ctl_s3      (ctl_s3),
		.wmin_s3     (wmin_s3),
		.wmax_s3     (wmax_s3),
		.fix_s3      (fix_s3),
		.sgn_case_s3 (sgn_case_s3)
	);

	ibk_final_stage #(
		.WIDTH (WIDTH)
	) u_final (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ctl_s3      (ctl_s3),
		.wmin_s3     (wmin_s3),
		.wmax_s3     (wmax_s3),
		.fix_s3      (fix_s3),
		.sgn_case_s3 (sgn_case_s3),
		.ctl_s4      (ctl_s4),
		.res_lo_s4   (res_lo),
		.res_hi_s4   (res_hi),
		.ok_s4       (ok)
	);

endmodule
